// ===== hdl/rds_pkg.sv =====
// Shared types and codes for the record deque store.
`default_nettype none

package rds_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned FIELD_W  = 3;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_WRITE_LAST = 3'd2,
    MODE_READ       = 3'd3,
    MODE_POP_FRONT  = 3'd4,
    MODE_POP_BACK   = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_e;

  typedef enum logic [FIELD_W-1:0] {
    FLD_INPUT_TIME  = 3'd1,
    FLD_HEIGHT      = 3'd2,
    FLD_METAL       = 3'd3,
    FLD_OUTPUT_TIME = 3'd4
  } field_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_BAD_FIELD = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] input_time;
    logic               height;
    logic               metal;
    logic [VALUE_W-1:0] output_time;
  } record_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic   push_front;
    logic   pop_front;
    logic   wr_en;
    field_e field;
    logic   rd_load;
    logic   rd_shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/record_deque_store.sv =====
// Every operation but a read registers its result beat in the cycle after acceptance.
// A successful read at position p loads the selected field into every cell; the field then
// walks one cell per cycle along the read shift line to the front cell.
// Throughput: one operation per cycle while in_stall_o is low; a read or a stalled result beat raises it.
// Reset: asynchronous, clears the count, the read sequencer and the result valid; records
// are not cleared and read as undefined until written.
`default_nettype none

module record_deque_store #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [rds_pkg::MODE_W-1:0]    mode_i,
  input  wire  [rds_pkg::POS_W-1:0]     position_i,
  input  wire  [rds_pkg::FIELD_W-1:0]   field_select_i,
  input  wire  [rds_pkg::VALUE_W-1:0]   write_value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [rds_pkg::STATUS_W-1:0]  status_o,
  output logic [rds_pkg::VALUE_W-1:0]   read_value_o,
  output logic [rds_pkg::COUNT_W-1:0]   entry_count_o
);

  import rds_pkg::*;

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  cell_ctrl_t         cell_ctrl;
  logic [IDXW-1:0]    wr_slot;
  record_t            rec   [DEPTH];
  logic [VALUE_W-1:0] carry [DEPTH];

  rds_ctrl #(
    .DEPTH (DEPTH),
    .IDXW  (IDXW),
    .CNTW  (CNTW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .field_select_i (field_select_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .entry_count_o  (entry_count_o),
    .carry_i        (carry[0]),
    .cell_ctrl_o    (cell_ctrl),
    .wr_slot_o      (wr_slot)
  );

  // Cell 0 holds the front record; the row shifts on push and pop at the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    record_t            left_rec, right_rec;
    logic [VALUE_W-1:0] right_carry;

    if (i == 0) begin : g_first
      assign left_rec = '0;
    end else begin : g_mid
      assign left_rec = rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec   = '0;
      assign right_carry = '0;
    end else begin : g_inner
      assign right_rec   = rec[i+1];
      assign right_carry = carry[i+1];
    end

    rds_cell #(
      .IDX  (i),
      .IDXW (IDXW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .wr_slot_i  (wr_slot),
      .wr_value_i (write_value_i),
      .left_i     (left_rec),
      .right_i    (right_rec),
      .carry_i    (right_carry),
      .record_o   (rec[i]),
      .carry_o    (carry[i])
    );
  end

endmodule

`default_nettype wire

// ===== hdl/rds_cell.sv =====
// One cell of the row: a single record plus one stage of the read shift line.
`default_nettype none

module rds_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IDXW = 6
) (
  input  wire                          clk_i,
  input  rds_pkg::cell_ctrl_t          ctrl_i,
  input  wire  [IDXW-1:0]              wr_slot_i,
  input  wire  [rds_pkg::VALUE_W-1:0]  wr_value_i,
  input  rds_pkg::record_t             left_i,
  input  rds_pkg::record_t             right_i,
  input  wire  [rds_pkg::VALUE_W-1:0]  carry_i,
  output rds_pkg::record_t             record_o,
  output logic [rds_pkg::VALUE_W-1:0]  carry_o
);

  import rds_pkg::*;

  record_t            record_q, record_d;
  logic [VALUE_W-1:0] carry_q, carry_d;
  logic [VALUE_W-1:0] own_field;
  logic               hit;

  assign hit = (wr_slot_i == IDXW'(IDX));

  always_comb begin
    record_d = record_q;
    if (ctrl_i.pop_front) begin
      record_d = right_i;
    end else if (ctrl_i.push_front) begin
      record_d = left_i;
    end else if (ctrl_i.wr_en && hit) begin
      case (ctrl_i.field)
        FLD_INPUT_TIME:  record_d.input_time  = wr_value_i;
        FLD_HEIGHT:      record_d.height      = wr_value_i[0];
        FLD_METAL:       record_d.metal       = wr_value_i[0];
        FLD_OUTPUT_TIME: record_d.output_time = wr_value_i;
        default:         record_d             = record_q;
      endcase
    end
  end

  always_comb begin
    case (ctrl_i.field)
      FLD_INPUT_TIME:  own_field = record_q.input_time;
      FLD_HEIGHT:      own_field = {{(VALUE_W-1){1'b0}}, record_q.height};
      FLD_METAL:       own_field = {{(VALUE_W-1){1'b0}}, record_q.metal};
      FLD_OUTPUT_TIME: own_field = record_q.output_time;
      default:         own_field = '0;
    endcase
  end

  // Load the selected field, then pass it one cell towards the front each cycle.
  always_comb begin
    carry_d = carry_q;
    if (ctrl_i.rd_load) begin
      carry_d = own_field;
    end else if (ctrl_i.rd_shift) begin
      carry_d = carry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    record_q <= record_d;
    carry_q  <= carry_d;
  end

  assign record_o = record_q;
  assign carry_o  = carry_q;

endmodule

`default_nettype wire

// ===== hdl/rds_ctrl.sv =====
// Controller: decodes operations, keeps the record count, runs reads and holds the result beat.
`default_nettype none

module rds_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDXW  = 6,
  parameter int unsigned CNTW  = 7
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [rds_pkg::MODE_W-1:0]    mode_i,
  input  wire  [rds_pkg::POS_W-1:0]     position_i,
  input  wire  [rds_pkg::FIELD_W-1:0]   field_select_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [rds_pkg::STATUS_W-1:0]  status_o,
  output logic [rds_pkg::VALUE_W-1:0]   read_value_o,
  output logic [rds_pkg::COUNT_W-1:0]   entry_count_o,
  input  wire  [rds_pkg::VALUE_W-1:0]   carry_i,
  output rds_pkg::cell_ctrl_t           cell_ctrl_o,
  output logic [IDXW-1:0]               wr_slot_o
);

  import rds_pkg::*;

  localparam int unsigned CMPW = (CNTW > POS_W) ? CNTW : POS_W;

  state_e             state_q, state_d;
  logic [CNTW-1:0]    count_q, count_d, count_m1;
  logic [IDXW-1:0]    left_q, left_d;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [VALUE_W-1:0] rdata_q, rdata_d;
  logic [COUNT_W-1:0] ocount_q, ocount_d;

  mode_e              mode;
  field_e             field;
  status_e            op_status;
  logic [CMPW-1:0]    pos_m1;
  logic               out_free, accept, full, empty, field_ok, pos_over;
  logic               start_read, finish;

  assign mode  = mode_e'(mode_i);
  assign field = field_e'(field_select_i);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign full      = (count_q == CNTW'(DEPTH));
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - CNTW'(1);
  assign wr_slot_o = count_m1[IDXW-1:0];
  assign pos_m1    = CMPW'(position_i) - CMPW'(1);
  assign pos_over  = CMPW'(position_i) > CMPW'(count_q);

  always_comb begin
    case (field)
      FLD_INPUT_TIME, FLD_HEIGHT, FLD_METAL, FLD_OUTPUT_TIME: field_ok = 1'b1;
      default:                                                field_ok = 1'b0;
    endcase
  end

  assign finish = (state_q == ST_READ) && (left_q == '0) && out_free;

  // Operation decode and cell control
  always_comb begin
    op_status   = STAT_OK;
    count_d     = count_q;
    start_read  = 1'b0;
    cell_ctrl_o = '0;
    cell_ctrl_o.field    = field;
    cell_ctrl_o.rd_shift = (state_q == ST_READ) && (left_q != '0);
    if (accept) begin
      case (mode)
        MODE_PUSH_BACK: begin
          if (full) op_status = STAT_FULL;
          else      count_d   = count_q + CNTW'(1);
        end
        MODE_PUSH_FRONT: begin
          if (full) begin
            op_status = STAT_FULL;
          end else begin
            count_d                = count_q + CNTW'(1);
            cell_ctrl_o.push_front = 1'b1;
          end
        end
        MODE_WRITE_LAST: begin
          if (empty)          op_status         = STAT_EMPTY;
          else if (!field_ok) op_status         = STAT_BAD_FIELD;
          else                cell_ctrl_o.wr_en = 1'b1;
        end
        MODE_READ: begin
          if (position_i == '0) begin
            op_status = STAT_BAD_POS;
          end else if (!field_ok) begin
            op_status = STAT_BAD_FIELD;
          end else if (empty) begin
            op_status = STAT_EMPTY;
          end else if (pos_over) begin
            op_status = STAT_BAD_POS;
          end else begin
            start_read          = 1'b1;
            cell_ctrl_o.rd_load = 1'b1;
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            op_status = STAT_EMPTY;
          end else begin
            count_d               = count_m1;
            cell_ctrl_o.pop_front = 1'b1;
          end
        end
        MODE_POP_BACK: begin
          if (empty) op_status = STAT_EMPTY;
          else       count_d   = count_m1;
        end
        MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_read) state_d = ST_READ;
      ST_READ: if (finish)     state_d = ST_IDLE;
      default:                 state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    left_d = left_q;
    if (start_read) begin
      left_d = pos_m1[IDXW-1:0];
    end else if (cell_ctrl_o.rd_shift) begin
      left_d = left_q - IDXW'(1);
    end
  end

  // Result beat
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    ocount_d    = ocount_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (accept && !start_read) begin
      out_valid_d = 1'b1;
      status_d    = op_status;
      rdata_d     = '0;
      ocount_d    = COUNT_W'(count_d);
    end else if (finish) begin
      out_valid_d = 1'b1;
      status_d    = STAT_OK;
      rdata_d     = carry_i;
      ocount_d    = COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rdata_q  <= rdata_d;
    ocount_q <= ocount_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rdata_q;
  assign entry_count_o = ocount_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(DEPTH))
    else $error("record count beyond depth");

  a_full_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (mode == MODE_PUSH_BACK || mode == MODE_PUSH_FRONT)
    |=> count_q == $past(count_q))
    else $error("refused push changed the count");

  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_read |=> state_q == ST_READ && !out_valid_q == !$past(out_valid_d))
    else $error("read did not enter the read state");

  a_read_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ && left_q != '0
    |=> state_q == ST_READ && left_q == $past(left_q) - IDXW'(1))
    else $error("read countdown skipped a step");
`endif

endmodule

`default_nettype wire
